### rtl/core/ttsc_pkg.sv
// ----------------------------------------------------------------------------
// ttsc_pkg: shared types and float helpers for the tridiagonal solver
// payload structs, controller codes, command/status bundles and the
// single-precision normalize and round-to-nearest-even helpers
// ----------------------------------------------------------------------------
package ttsc_pkg;

   localparam int MAX_ROWS_DEF = 64;
   localparam int ROW_W = 6;
   localparam logic [31:0] QNAN_DEF = 32'hFFC0_0000;

   typedef struct packed {
      logic [31:0] sub_diag;
      logic [31:0] main_diag;
      logic [31:0] super_diag;
      logic [31:0] rhs_value;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [31:0]      solution;
      logic [ROW_W-1:0] row_index;
      logic             last_result;
      logic             overflow;
   } rsp_type;

   typedef enum logic [1:0] {FOP_MUL, FOP_SUB, FOP_RCP} fop_type;

   typedef enum logic [3:0] {
      SRC_A, SRC_B, SRC_D, SRC_PINV, SRC_PUP, SRC_PRHS,
      SRC_R, SRC_T, SRC_X, SRC_MINV, SRC_MUP, SRC_MRHS
   } src_type;

   typedef enum logic [2:0] {DST_R, DST_T, DST_INV, DST_RHS, DST_X} dst_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_F_INV0, ST_F_R, ST_F_CR, ST_F_PIV, ST_F_INV, ST_F_RD, ST_F_RHS,
      ST_COMMIT, ST_B_RD, ST_B_X0, ST_B_CX, ST_B_T, ST_B_X, ST_B_EMIT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             issue;
      fop_type          op;
      src_type          src_a;
      src_type          src_b;
      dst_type          dst;
      logic             commit;
      logic             row0;
      logic             mem_rd;
      logic [ROW_W-1:0] row;
      logic             emit;
      logic             last;
      logic             ovf;
   } cmd_type;

   typedef struct packed {
      logic fpu_done;
   } stat_type;

   function automatic logic is_nan(input logic [31:0] x);
      return (&x[30:23]) & (|x[22:0]);
   endfunction

   function automatic logic is_inf(input logic [31:0] x);
      return (&x[30:23]) & ~(|x[22:0]);
   endfunction

   function automatic logic [31:0] quiet(input logic [31:0] x);
      return {x[31:23], 1'b1, x[21:0]};
   endfunction

   // leading zero count, 27 when all zero
   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      n = 5'd27;
      for (int i = 0; i < 27; i++) begin
         if (v[i]) n = 5'(26 - i);
      end
      return n;
   endfunction

   // {biased exponent (signed 10), significand with leading one}
   function automatic logic [33:0] norm_unp(input logic [31:0] x);
      logic [23:0] s;
      logic [4:0]  lz;
      logic [9:0]  e;
      s = {|x[30:23], x[22:0]};
      lz = lzc27({s, 3'b000});
      s = s << lz;
      e = (x[30:23] == 8'd0) ? 10'd1 : {2'b00, x[30:23]};
      e = e - {5'd0, lz};
      return {e, s};
   endfunction

   // m[26] is the leading one, m[2:0] guard, round, sticky
   function automatic logic [31:0] pack_rne(input logic s, input logic signed [9:0] e,
                                            input logic [26:0] m);
      logic [4:0]  sh;
      logic [26:0] ms;
      logic        st;
      logic [7:0]  ef;
      logic        inc;
      logic [30:0] mag;
      if (e >= 10'sd255) return {s, 8'hFF, 23'd0};
      if (e <= 10'sd0) begin
         sh = (e < -10'sd25) ? 5'd27 : 5'(10'sd1 - e);
         ms = m >> sh;
         st = |(m & ~({27{1'b1}} << sh));
         ms[0] = ms[0] | st;
         ef = 8'd0;
      end else begin
         ms = m;
         ef = e[7:0];
      end
      inc = ms[2] & (ms[3] | ms[1] | ms[0]);
      mag = {ef, ms[25:3]} + {30'd0, inc};
      return {s, mag};
   endfunction

endpackage

### rtl/core/ttsc_fpu.sv
// ----------------------------------------------------------------------------
// ttsc_fpu: single-precision multiply, subtract and reciprocal
// one operation at a time; multiply and subtract are short pipelines,
// the reciprocal is a bit-per-cycle restoring divider
// ----------------------------------------------------------------------------
module ttsc_fpu (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  ttsc_pkg::fop_type op,
   input  logic [31:0]      opa,
   input  logic [31:0]      opb,
   output logic             done,
   output logic [31:0]      result
);

   logic        done_ff;
   logic [31:0] res_ff;

   // ---------------- multiply ----------------
   logic               m_start;
   logic               m_sp;
   logic [31:0]        m_sv;
   logic signed [9:0]  m_ea, m_eb;
   logic [23:0]        m_sa, m_sb;
   logic               m_v1_ff, m_v2_ff, m_v3_ff;
   logic               m_s1_ff, m_s2_ff, m_s3_ff;
   logic               m_sp1_ff, m_sp2_ff, m_sp3_ff;
   logic [31:0]        m_sv1_ff, m_sv2_ff, m_sv3_ff;
   logic signed [9:0]  m_e1_ff, m_e2_ff, m_e3_ff;
   logic [23:0]        m_sa1_ff, m_sb1_ff;
   logic [47:0]        m_p2_ff;
   logic [26:0]        m_m3_ff;
   logic [31:0]        m_res;

   assign m_start = start && (op == ttsc_pkg::FOP_MUL);

   always_comb begin
      {m_ea, m_sa} = ttsc_pkg::norm_unp(opa);
      {m_eb, m_sb} = ttsc_pkg::norm_unp(opb);
      m_sp = 1'b1;
      if (ttsc_pkg::is_nan(opa)) m_sv = ttsc_pkg::quiet(opa);
      else if (ttsc_pkg::is_nan(opb)) m_sv = ttsc_pkg::quiet(opb);
      else if ((ttsc_pkg::is_inf(opa) && opb[30:0] == 31'd0) ||
               (ttsc_pkg::is_inf(opb) && opa[30:0] == 31'd0)) m_sv = ttsc_pkg::QNAN_DEF;
      else if (ttsc_pkg::is_inf(opa) || ttsc_pkg::is_inf(opb))
         m_sv = {opa[31] ^ opb[31], 8'hFF, 23'd0};
      else if (opa[30:0] == 31'd0 || opb[30:0] == 31'd0)
         m_sv = {opa[31] ^ opb[31], 31'd0};
      else begin
         m_sp = 1'b0;
         m_sv = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v1_ff <= 1'b0;
         m_v2_ff <= 1'b0;
         m_v3_ff <= 1'b0;
      end else begin
         m_v1_ff <= m_start;
         m_v2_ff <= m_v1_ff;
         m_v3_ff <= m_v2_ff;
      end
      m_s1_ff  <= opa[31] ^ opb[31];
      m_sp1_ff <= m_sp;
      m_sv1_ff <= m_sv;
      m_e1_ff  <= m_ea + m_eb - 10'sd127;
      m_sa1_ff <= m_sa;
      m_sb1_ff <= m_sb;
      // product register
      m_s2_ff  <= m_s1_ff;
      m_sp2_ff <= m_sp1_ff;
      m_sv2_ff <= m_sv1_ff;
      m_e2_ff  <= m_e1_ff;
      m_p2_ff  <= m_sa1_ff * m_sb1_ff;
      // product lies in [1,4): at most one right shift
      m_s3_ff  <= m_s2_ff;
      m_sp3_ff <= m_sp2_ff;
      m_sv3_ff <= m_sv2_ff;
      if (m_p2_ff[47]) begin
         m_m3_ff <= {m_p2_ff[47:22], |m_p2_ff[21:0]};
         m_e3_ff <= m_e2_ff + 10'sd1;
      end else begin
         m_m3_ff <= {m_p2_ff[46:21], |m_p2_ff[20:0]};
         m_e3_ff <= m_e2_ff;
      end
   end

   assign m_res = m_sp3_ff ? m_sv3_ff : ttsc_pkg::pack_rne(m_s3_ff, m_e3_ff, m_m3_ff);

   // ---------------- subtract ----------------
   logic               a_start;
   logic [31:0]        a_bn, a_big, a_sml;
   logic               a_sp;
   logic [31:0]        a_sv;
   logic [7:0]         a_eb, a_es, a_d;
   logic [4:0]         a_sh;
   logic [26:0]        a_mb, a_ms0, a_ms;
   logic               a_v1_ff, a_v2_ff, a_v3_ff, a_v4_ff;
   logic               a_s1_ff, a_s2_ff, a_s3_ff, a_s4_ff;
   logic               a_sub1_ff;
   logic               a_zs1_ff, a_zs2_ff, a_zs3_ff, a_zs4_ff;
   logic               a_sp1_ff, a_sp2_ff, a_sp3_ff, a_sp4_ff;
   logic [31:0]        a_sv1_ff, a_sv2_ff, a_sv3_ff, a_sv4_ff;
   logic signed [9:0]  a_e1_ff, a_e2_ff, a_e3_ff, a_e4_ff;
   logic [26:0]        a_mb1_ff, a_ms1_ff;
   logic [27:0]        a_sum2_ff, a_sum3_ff;
   logic [4:0]         a_lz3_ff;
   logic [26:0]        a_m4_ff;
   logic               a_z4_ff;
   logic [31:0]        a_res;

   assign a_start = start && (op == ttsc_pkg::FOP_SUB);

   always_comb begin
      a_bn = {~opb[31], opb[30:0]};
      a_sp = 1'b1;
      if (ttsc_pkg::is_nan(opa)) a_sv = ttsc_pkg::quiet(opa);
      else if (ttsc_pkg::is_nan(opb)) a_sv = ttsc_pkg::quiet(opb);
      else if (ttsc_pkg::is_inf(opa) && ttsc_pkg::is_inf(opb) && (opa[31] != a_bn[31]))
         a_sv = ttsc_pkg::QNAN_DEF;
      else if (ttsc_pkg::is_inf(opa)) a_sv = opa;
      else if (ttsc_pkg::is_inf(opb)) a_sv = a_bn;
      else begin
         a_sp = 1'b0;
         a_sv = 32'd0;
      end
      if (opa[30:0] >= opb[30:0]) begin
         a_big = opa;
         a_sml = a_bn;
      end else begin
         a_big = a_bn;
         a_sml = opa;
      end
      a_eb = (a_big[30:23] == 8'd0) ? 8'd1 : a_big[30:23];
      a_es = (a_sml[30:23] == 8'd0) ? 8'd1 : a_sml[30:23];
      a_d  = a_eb - a_es;
      a_sh = (a_d > 8'd27) ? 5'd27 : a_d[4:0];
      a_mb = {|a_big[30:23], a_big[22:0], 3'b000};
      a_ms0 = {|a_sml[30:23], a_sml[22:0], 3'b000};
      a_ms = a_ms0 >> a_sh;
      a_ms[0] = a_ms[0] | (|(a_ms0 & ~({27{1'b1}} << a_sh)));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v1_ff <= 1'b0;
         a_v2_ff <= 1'b0;
         a_v3_ff <= 1'b0;
         a_v4_ff <= 1'b0;
      end else begin
         a_v1_ff <= a_start;
         a_v2_ff <= a_v1_ff;
         a_v3_ff <= a_v2_ff;
         a_v4_ff <= a_v3_ff;
      end
      // aligned operands
      a_s1_ff   <= a_big[31];
      a_sub1_ff <= opa[31] ^ a_bn[31];
      a_zs1_ff  <= opa[31] & a_bn[31];
      a_sp1_ff  <= a_sp;
      a_sv1_ff  <= a_sv;
      a_e1_ff   <= {2'b00, a_eb};
      a_mb1_ff  <= a_mb;
      a_ms1_ff  <= a_ms;
      // magnitude add or subtract
      a_s2_ff  <= a_s1_ff;
      a_zs2_ff <= a_zs1_ff;
      a_sp2_ff <= a_sp1_ff;
      a_sv2_ff <= a_sv1_ff;
      a_e2_ff  <= a_e1_ff;
      a_sum2_ff <= a_sub1_ff ? ({1'b0, a_mb1_ff} - {1'b0, a_ms1_ff})
                             : ({1'b0, a_mb1_ff} + {1'b0, a_ms1_ff});
      // leading zero count
      a_s3_ff   <= a_s2_ff;
      a_zs3_ff  <= a_zs2_ff;
      a_sp3_ff  <= a_sp2_ff;
      a_sv3_ff  <= a_sv2_ff;
      a_e3_ff   <= a_e2_ff;
      a_sum3_ff <= a_sum2_ff;
      a_lz3_ff  <= ttsc_pkg::lzc27(a_sum2_ff[26:0]);
      // normalize
      a_s4_ff  <= a_s3_ff;
      a_zs4_ff <= a_zs3_ff;
      a_sp4_ff <= a_sp3_ff;
      a_sv4_ff <= a_sv3_ff;
      a_z4_ff  <= (a_sum3_ff == 28'd0);
      if (a_sum3_ff[27]) begin
         a_m4_ff <= {a_sum3_ff[27:2], |a_sum3_ff[1:0]};
         a_e4_ff <= a_e3_ff + 10'sd1;
      end else begin
         a_m4_ff <= a_sum3_ff[26:0] << a_lz3_ff;
         a_e4_ff <= a_e3_ff - $signed({5'd0, a_lz3_ff});
      end
   end

   always_comb begin
      if (a_sp4_ff) a_res = a_sv4_ff;
      else if (a_z4_ff) a_res = {a_zs4_ff, 31'd0};
      else a_res = ttsc_pkg::pack_rne(a_s4_ff, a_e4_ff, a_m4_ff);
   end

   // ---------------- reciprocal ----------------
   logic               r_start;
   logic               r_sp;
   logic [31:0]        r_sv;
   logic signed [9:0]  r_eu;
   logic [23:0]        r_su;
   logic               r_busy_ff, r_fin_ff;
   logic [4:0]         r_cnt_ff;
   logic [24:0]        r_rem_ff;
   logic [24:0]        r_diff;
   logic [23:0]        r_d_ff;
   logic [27:0]        r_q_ff;
   logic signed [9:0]  r_e_ff;
   logic               r_s_ff, r_sp_ff;
   logic [31:0]        r_sv_ff;
   logic               r_ge;
   logic               r_st;
   logic [31:0]        r_res;

   assign r_start = start && (op == ttsc_pkg::FOP_RCP);

   always_comb begin
      {r_eu, r_su} = ttsc_pkg::norm_unp(opb);
      r_sp = 1'b1;
      if (ttsc_pkg::is_nan(opb)) r_sv = ttsc_pkg::quiet(opb);
      else if (ttsc_pkg::is_inf(opb)) r_sv = {opb[31], 31'd0};
      else if (opb[30:0] == 31'd0) r_sv = {opb[31], 8'hFF, 23'd0};
      else begin
         r_sp = 1'b0;
         r_sv = 32'd0;
      end
      r_ge   = (r_rem_ff >= {1'b0, r_d_ff});
      r_diff = r_ge ? (r_rem_ff - {1'b0, r_d_ff}) : r_rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_busy_ff <= 1'b0;
         r_fin_ff  <= 1'b0;
         r_cnt_ff  <= 5'd0;
      end else if (r_start) begin
         r_busy_ff <= ~r_sp;
         r_fin_ff  <= r_sp;
         r_cnt_ff  <= 5'd0;
      end else if (r_busy_ff) begin
         r_cnt_ff <= r_cnt_ff + 5'd1;
         if (r_cnt_ff == 5'd27) begin
            r_busy_ff <= 1'b0;
            r_fin_ff  <= 1'b1;
         end
      end else begin
         r_fin_ff <= 1'b0;
      end
      if (r_start) begin
         r_rem_ff <= 25'd1 << 23;
         r_d_ff   <= r_su;
         r_e_ff   <= r_eu;
         r_s_ff   <= opb[31];
         r_sp_ff  <= r_sp;
         r_sv_ff  <= r_sv;
         r_q_ff   <= 28'd0;
      end else if (r_busy_ff) begin
         r_rem_ff <= {r_diff[23:0], 1'b0};
         r_q_ff   <= {r_q_ff[26:0], r_ge};
      end
   end

   always_comb begin
      r_st = (r_rem_ff != 25'd0);
      if (r_sp_ff) r_res = r_sv_ff;
      else if (r_q_ff[27])
         r_res = ttsc_pkg::pack_rne(r_s_ff, 10'sd254 - r_e_ff,
                                    {r_q_ff[27:2], r_q_ff[1] | r_q_ff[0] | r_st});
      else
         r_res = ttsc_pkg::pack_rne(r_s_ff, 10'sd253 - r_e_ff,
                                    {r_q_ff[26:1], r_q_ff[0] | r_st});
   end

   // ---------------- result ----------------
   always_ff @(posedge clock) begin
      if (reset) done_ff <= 1'b0;
      else done_ff <= m_v3_ff | a_v4_ff | r_fin_ff;
      if (m_v3_ff) res_ff <= m_res;
      else if (a_v4_ff) res_ff <= a_res;
      else if (r_fin_ff) res_ff <= r_res;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

### rtl/core/ttsc_datapath.sv
// ----------------------------------------------------------------------------
// ttsc_datapath: row registers, coefficient store and the shared fp unit
// operands are picked and results written back as the controller commands
// ----------------------------------------------------------------------------
module ttsc_datapath #(
   parameter int MAX_ROWS = ttsc_pkg::MAX_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ttsc_pkg::req_type req_data,
   input  ttsc_pkg::cmd_type cmd,
   output ttsc_pkg::stat_type stat,
   output ttsc_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_ROWS);

   logic [31:0] a_ff, b_ff, c_ff, d_ff;
   logic [31:0] r_ff, t_ff, inv_ff, rhs_ff, x_ff;
   logic [31:0] pinv_ff, pup_ff, prhs_ff;
   logic [31:0] minv_ff, mup_ff, mrhs_ff;
   ttsc_pkg::dst_type dst_ff;
   ttsc_pkg::rsp_type rsp_ff;
   logic [95:0] mem [MAX_ROWS];
   logic [31:0] rhs_sel;
   logic [31:0] opa, opb;
   logic        fpu_done;
   logic [31:0] fpu_res;

   function automatic logic [31:0] pick(input ttsc_pkg::src_type s,
                                        input logic [383:0] v);
      logic [31:0] o;
      case (s)
         ttsc_pkg::SRC_A:    o = v[31:0];
         ttsc_pkg::SRC_B:    o = v[63:32];
         ttsc_pkg::SRC_D:    o = v[95:64];
         ttsc_pkg::SRC_PINV: o = v[127:96];
         ttsc_pkg::SRC_PUP:  o = v[159:128];
         ttsc_pkg::SRC_PRHS: o = v[191:160];
         ttsc_pkg::SRC_R:    o = v[223:192];
         ttsc_pkg::SRC_T:    o = v[255:224];
         ttsc_pkg::SRC_X:    o = v[287:256];
         ttsc_pkg::SRC_MINV: o = v[319:288];
         ttsc_pkg::SRC_MUP:  o = v[351:320];
         ttsc_pkg::SRC_MRHS: o = v[383:352];
         default:            o = 32'd0;
      endcase
      return o;
   endfunction

   logic [383:0] srcs;
   assign srcs = {mrhs_ff, mup_ff, minv_ff, x_ff, t_ff, r_ff,
                  prhs_ff, pup_ff, pinv_ff, d_ff, b_ff, a_ff};
   assign opa = pick(cmd.src_a, srcs);
   assign opb = pick(cmd.src_b, srcs);
   assign rhs_sel = cmd.row0 ? d_ff : rhs_ff;

   ttsc_fpu u_fpu (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.issue),
      .op     (cmd.op),
      .opa    (opa),
      .opb    (opb),
      .done   (fpu_done),
      .result (fpu_res)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= req_data.sub_diag;
         b_ff <= req_data.main_diag;
         c_ff <= req_data.super_diag;
         d_ff <= req_data.rhs_value;
      end
      if (cmd.issue) dst_ff <= cmd.dst;
      if (fpu_done) begin
         case (dst_ff)
            ttsc_pkg::DST_R:   r_ff   <= fpu_res;
            ttsc_pkg::DST_T:   t_ff   <= fpu_res;
            ttsc_pkg::DST_INV: inv_ff <= fpu_res;
            ttsc_pkg::DST_RHS: rhs_ff <= fpu_res;
            ttsc_pkg::DST_X:   x_ff   <= fpu_res;
            default:           t_ff   <= fpu_res;
         endcase
      end
      // row done: becomes the previous row for the next one
      if (cmd.commit) begin
         pinv_ff <= inv_ff;
         pup_ff  <= c_ff;
         prhs_ff <= rhs_sel;
      end
      if (cmd.emit) begin
         rsp_ff.solution    <= x_ff;
         rsp_ff.row_index   <= cmd.row;
         rsp_ff.last_result <= cmd.last;
         rsp_ff.overflow    <= cmd.ovf;
      end
   end

   // coefficient store: inv pivot, super diagonal, modified rhs
   always_ff @(posedge clock) begin
      if (cmd.commit) mem[cmd.row[IDX_W-1:0]] <= {inv_ff, c_ff, rhs_sel};
      if (cmd.mem_rd) {minv_ff, mup_ff, mrhs_ff} <= mem[cmd.row[IDX_W-1:0]];
   end

   assign stat.fpu_done = fpu_done;
   assign rsp_data      = rsp_ff;

endmodule

### rtl/core/ttsc_ctrl.sv
// ----------------------------------------------------------------------------
// ttsc_ctrl: sequencer for the forward sweep and back substitution
// issues one fp operation at a time and runs the result handshake
// ----------------------------------------------------------------------------
module ttsc_ctrl #(
   parameter int MAX_ROWS = ttsc_pkg::MAX_ROWS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_is_last,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  ttsc_pkg::stat_type stat,
   output ttsc_pkg::cmd_type  cmd
);

   localparam logic [ttsc_pkg::ROW_W-1:0] LAST_IDX = ttsc_pkg::ROW_W'(MAX_ROWS - 1);
   localparam logic [ttsc_pkg::ROW_W-1:0] ONE_IDX  = ttsc_pkg::ROW_W'(1);

   ttsc_pkg::state_type state_ff, state_in, step_next;
   logic                      busy_ff, busy_in;
   logic [ttsc_pkg::ROW_W-1:0] cnt_ff, cnt_in;
   logic [ttsc_pkg::ROW_W-1:0] bidx_ff, bidx_in;
   logic                      last_ff, last_in;
   logic                      ovf_ff, ovf_in;
   logic                      first_ff, first_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      step;
   logic                      ovf_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttsc_pkg::ST_IDLE;
         busy_ff      <= 1'b0;
         cnt_ff       <= '0;
         bidx_ff      <= '0;
         last_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         cnt_ff       <= cnt_in;
         bidx_ff      <= bidx_in;
         last_ff      <= last_in;
         ovf_ff       <= ovf_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      bidx_in      = bidx_ff;
      last_in      = last_ff;
      ovf_in       = ovf_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = 1'b0;
      step         = 1'b0;
      step_next    = ttsc_pkg::ST_IDLE;
      ovf_now      = ~req_is_last && (cnt_ff == LAST_IDX);

      unique case (state_ff)
         ttsc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               ovf_in   = ovf_now;
               last_in  = req_is_last | ovf_now;
               state_in = (cnt_ff == '0) ? ttsc_pkg::ST_F_INV0 : ttsc_pkg::ST_F_R;
            end
         end
         ttsc_pkg::ST_F_INV0: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_RCP;
            cmd.src_a = ttsc_pkg::SRC_B; cmd.src_b = ttsc_pkg::SRC_B;
            cmd.dst = ttsc_pkg::DST_INV; step_next = ttsc_pkg::ST_COMMIT;
         end
         ttsc_pkg::ST_F_R: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_MUL;
            cmd.src_a = ttsc_pkg::SRC_A; cmd.src_b = ttsc_pkg::SRC_PINV;
            cmd.dst = ttsc_pkg::DST_R; step_next = ttsc_pkg::ST_F_CR;
         end
         ttsc_pkg::ST_F_CR: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_MUL;
            cmd.src_a = ttsc_pkg::SRC_PUP; cmd.src_b = ttsc_pkg::SRC_R;
            cmd.dst = ttsc_pkg::DST_T; step_next = ttsc_pkg::ST_F_PIV;
         end
         ttsc_pkg::ST_F_PIV: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_SUB;
            cmd.src_a = ttsc_pkg::SRC_B; cmd.src_b = ttsc_pkg::SRC_T;
            cmd.dst = ttsc_pkg::DST_T; step_next = ttsc_pkg::ST_F_INV;
         end
         ttsc_pkg::ST_F_INV: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_RCP;
            cmd.src_a = ttsc_pkg::SRC_T; cmd.src_b = ttsc_pkg::SRC_T;
            cmd.dst = ttsc_pkg::DST_INV; step_next = ttsc_pkg::ST_F_RD;
         end
         ttsc_pkg::ST_F_RD: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_MUL;
            cmd.src_a = ttsc_pkg::SRC_R; cmd.src_b = ttsc_pkg::SRC_PRHS;
            cmd.dst = ttsc_pkg::DST_T; step_next = ttsc_pkg::ST_F_RHS;
         end
         ttsc_pkg::ST_F_RHS: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_SUB;
            cmd.src_a = ttsc_pkg::SRC_D; cmd.src_b = ttsc_pkg::SRC_T;
            cmd.dst = ttsc_pkg::DST_RHS; step_next = ttsc_pkg::ST_COMMIT;
         end
         ttsc_pkg::ST_COMMIT: begin
            cmd.commit = 1'b1;
            cmd.row    = cnt_ff;
            cmd.row0   = (cnt_ff == '0);
            if (last_ff) begin
               bidx_in  = cnt_ff;
               cnt_in   = '0;
               first_in = 1'b1;
               state_in = ttsc_pkg::ST_B_RD;
            end else begin
               cnt_in   = cnt_ff + ONE_IDX;
               state_in = ttsc_pkg::ST_IDLE;
            end
         end
         ttsc_pkg::ST_B_RD: begin
            cmd.mem_rd = 1'b1;
            cmd.row    = bidx_ff;
            state_in   = first_ff ? ttsc_pkg::ST_B_X0 : ttsc_pkg::ST_B_CX;
         end
         ttsc_pkg::ST_B_X0: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_MUL;
            cmd.src_a = ttsc_pkg::SRC_MRHS; cmd.src_b = ttsc_pkg::SRC_MINV;
            cmd.dst = ttsc_pkg::DST_X; step_next = ttsc_pkg::ST_B_EMIT;
         end
         ttsc_pkg::ST_B_CX: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_MUL;
            cmd.src_a = ttsc_pkg::SRC_MUP; cmd.src_b = ttsc_pkg::SRC_X;
            cmd.dst = ttsc_pkg::DST_T; step_next = ttsc_pkg::ST_B_T;
         end
         ttsc_pkg::ST_B_T: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_SUB;
            cmd.src_a = ttsc_pkg::SRC_MRHS; cmd.src_b = ttsc_pkg::SRC_T;
            cmd.dst = ttsc_pkg::DST_T; step_next = ttsc_pkg::ST_B_X;
         end
         ttsc_pkg::ST_B_X: begin
            step = 1'b1; cmd.op = ttsc_pkg::FOP_MUL;
            cmd.src_a = ttsc_pkg::SRC_T; cmd.src_b = ttsc_pkg::SRC_MINV;
            cmd.dst = ttsc_pkg::DST_X; step_next = ttsc_pkg::ST_B_EMIT;
         end
         ttsc_pkg::ST_B_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               cmd.row      = bidx_ff;
               cmd.last     = (bidx_ff == '0);
               cmd.ovf      = ovf_ff;
               rsp_valid_in = 1'b1;
               first_in     = 1'b0;
               if (bidx_ff == '0) begin
                  state_in = ttsc_pkg::ST_IDLE;
               end else begin
                  bidx_in  = bidx_ff - ONE_IDX;
                  state_in = ttsc_pkg::ST_B_RD;
               end
            end
         end
         default: state_in = ttsc_pkg::ST_IDLE;
      endcase

      // issue once, then wait for the unit
      if (step) begin
         if (!busy_ff) begin
            cmd.issue = 1'b1;
            busy_in   = 1'b1;
         end else if (stat.fpu_done) begin
            busy_in  = 1'b0;
            state_in = step_next;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/core/tridiagonal_thomas_solver_core.sv
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver_core: Thomas algorithm tridiagonal solver
// single precision, round to nearest even, no pivoting
// ----------------------------------------------------------------------------
// Rows of one system enter one transaction at a time and the forward sweep
// runs as they arrive; the transaction carrying the last mark (or the row at
// index MAX_ROWS-1, which then flags overflow on every result) starts back
// substitution, which returns solutions from the highest row index down to
// row 0, the latter marked last_result. All arithmetic goes through one
// shared fp unit: multiply and subtract are pipelines and the reciprocal is a
// divider producing 28 quotient bits, one per cycle; a zero, infinite or NaN
// divisor skips the division loop. A new row is taken only once the previous
// row's sweep is done, and each solution waits for the output side to take
// the previous one; the reciprocal divider sets the pace of the sweep. A zero
// pivot yields infinity or NaN by IEEE rules and is not flagged. The result
// register lets the next system's rows be taken while the final result still
// waits on the output side.
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver_core #(
   parameter int MAX_ROWS = ttsc_pkg::MAX_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // row input transactions
   input  logic              req_valid,
   output logic              req_ready,
   input  ttsc_pkg::req_type req_data,
   // solution output transactions
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ttsc_pkg::rsp_type rsp_data
);

   ttsc_pkg::cmd_type  cmd;
   ttsc_pkg::stat_type stat;

   // sequencer: row count, sweep steps, back-substitution walk
   ttsc_ctrl #(
      .MAX_ROWS (MAX_ROWS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_data.is_last),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   // coefficient store, working registers and fp unit
   ttsc_datapath #(
      .MAX_ROWS (MAX_ROWS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

### test/ttsc_solution_checker.sv
// ----------------------------------------------------------------------------
// ttsc_solution_checker: scoreboard for the tridiagonal solver
// watches both channels, runs its own single-precision Thomas sweep on every
// accepted row and compares each returned solution with the oldest expected
// ----------------------------------------------------------------------------
module ttsc_solution_checker #(
   parameter int ROWS = ttsc_pkg::MAX_ROWS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  ttsc_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  ttsc_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                solutions_due,
   output int                solutions_seen,
   output int                cut_solutions
);

   localparam logic [31:0] FP_ONE = 32'h3F80_0000;
   localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;

   logic [31:0]       pivot_recip [ROWS];
   logic [31:0]       upper_diag [ROWS];
   logic [31:0]       swept_rhs [ROWS];
   int                rows_taken;
   ttsc_pkg::rsp_type solution_queue [$];

   function automatic logic fp_nan(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] != 0);
   endfunction

   function automatic logic fp_inf(input logic [31:0] x);
      return (x[30:23] == 8'hFF) && (x[22:0] == 0);
   endfunction

   function automatic logic [31:0] fp_quiet(input logic [31:0] x);
      return x | 32'h0040_0000;
   endfunction

   // significand with hidden bit and the weight of its lsb
   function automatic void fp_unpack(input logic [31:0] x, output logic [23:0] sig,
                                     output int e);
      if (x[30:23] == 0) begin
         sig = {1'b0, x[22:0]};
         e = -149;
      end else begin
         sig = {1'b1, x[22:0]};
         e = int'(x[30:23]) - 150;
      end
   endfunction

   // value is (m + fraction if st) * 2^e, rounded to nearest even
   function automatic logic [31:0] fp_round(input logic s, input int e, input logic [63:0] m,
                                            input logic st);
      int          p;
      int          shift;
      int          biased;
      logic [63:0] q;
      logic        g;
      logic        rest;
      if (m == 0) return {s, 31'd0};
      p = 0;
      for (int i = 0; i < 64; i++) if (m[i]) p = i;
      biased = p + e + 127;
      shift = (biased >= 1) ? p - 23 : -149 - e;
      if (shift >= 66) begin
         q = 0;
         g = 1'b0;
         rest = 1'b1;
      end else if (shift > 0) begin
         q = m >> shift;
         g = (shift <= 64) ? m[shift-1] : 1'b0;
         rest = st | ((m & ((64'd1 << (shift - 1)) - 64'd1)) != 0);
      end else begin
         q = m << (-shift);
         g = 1'b0;
         rest = st;
      end
      if (g && (rest || q[0])) q = q + 64'd1;
      if (biased >= 1) begin
         if (q[24]) begin
            q = q >> 1;
            biased++;
         end
         if (biased >= 255) return {s, 8'hFF, 23'd0};
         return {s, biased[7:0], q[22:0]};
      end
      // subnormal, a carry into bit 23 becomes the smallest normal
      return {s, q[30:0]};
   endfunction

   function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
      logic        s;
      logic [23:0] sa;
      logic [23:0] sb;
      int          ea;
      int          eb;
      if (fp_nan(a)) return fp_quiet(a);
      if (fp_nan(b)) return fp_quiet(b);
      s = a[31] ^ b[31];
      if (fp_inf(a) || fp_inf(b)) begin
         if (a[30:0] == 0 || b[30:0] == 0) return FP_DEFAULT_NAN;
         return {s, 8'hFF, 23'd0};
      end
      fp_unpack(a, sa, ea);
      fp_unpack(b, sb, eb);
      return fp_round(s, ea + eb, {40'd0, sa} * {40'd0, sb}, 1'b0);
   endfunction

   function automatic logic [31:0] fp_sub(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] nb;
      logic [31:0] hi;
      logic [31:0] lo;
      logic [23:0] sh;
      logic [23:0] sl;
      int          eh;
      int          el;
      int          diff;
      logic [63:0] mh;
      logic [63:0] m;
      logic        s;
      logic        st;
      int          e;
      if (fp_nan(a)) return fp_quiet(a);
      if (fp_nan(b)) return fp_quiet(b);
      nb = {~b[31], b[30:0]};
      if (fp_inf(a) && fp_inf(nb)) return (a[31] != nb[31]) ? FP_DEFAULT_NAN : a;
      if (fp_inf(a)) return a;
      if (fp_inf(nb)) return nb;
      if (nb[30:0] == 0) return (a[30:0] == 0) ? {a[31] & nb[31], 31'd0} : a;
      if (a[30:0] == 0) return nb;
      if (a[30:0] >= nb[30:0]) begin
         hi = a;
         lo = nb;
      end else begin
         hi = nb;
         lo = a;
      end
      fp_unpack(hi, sh, eh);
      fp_unpack(lo, sl, el);
      diff = eh - el;
      st = 1'b0;
      s = hi[31];
      if (diff > 36) begin
         // the small operand only nudges below the lsb
         e = eh - 3;
         mh = {40'd0, sh} << 3;
         m = (hi[31] == lo[31]) ? mh : mh - 64'd1;
         st = 1'b1;
      end else begin
         e = el;
         mh = {40'd0, sh} << diff;
         m = (hi[31] == lo[31]) ? mh + {40'd0, sl} : mh - {40'd0, sl};
         if (m == 0) return 32'd0;
      end
      return fp_round(s, e, m, st);
   endfunction

   function automatic logic [31:0] fp_recip(input logic [31:0] b);
      logic [23:0] sig;
      int          e;
      logic [63:0] q;
      logic [63:0] r;
      if (fp_nan(b)) return fp_quiet(b);
      if (fp_inf(b)) return {b[31], 31'd0};
      if (b[30:0] == 0) return {b[31], 8'hFF, 23'd0};
      fp_unpack(b, sig, e);
      q = (64'd1 << 62) / {40'd0, sig};
      r = (64'd1 << 62) % {40'd0, sig};
      return fp_round(b[31], -62 - e, q, r != 0);
   endfunction

   // forward sweep step; on the closing row queue the back substitution
   task automatic sweep_row(input ttsc_pkg::req_type row);
      int                idx;
      logic              cut;
      logic [31:0]       ratio;
      logic [31:0]       x;
      ttsc_pkg::rsp_type sol;
      idx = (rows_taken >= ROWS) ? ROWS - 1 : rows_taken;
      cut = !row.is_last && idx == ROWS - 1;
      if (idx == 0) begin
         pivot_recip[0] = fp_recip(row.main_diag);
         swept_rhs[0] = row.rhs_value;
      end else begin
         ratio = fp_mul(row.sub_diag, pivot_recip[idx-1]);
         pivot_recip[idx] = fp_recip(fp_sub(row.main_diag, fp_mul(upper_diag[idx-1], ratio)));
         swept_rhs[idx] = fp_sub(row.rhs_value, fp_mul(ratio, swept_rhs[idx-1]));
      end
      upper_diag[idx] = row.super_diag;
      if (!(row.is_last || cut)) begin
         rows_taken = idx + 1;
         return;
      end
      x = 32'd0;
      for (int i = idx; i >= 0; i--) begin
         if (i == idx) x = fp_mul(swept_rhs[i], pivot_recip[i]);
         else x = fp_mul(fp_sub(swept_rhs[i], fp_mul(upper_diag[i], x)), pivot_recip[i]);
         sol.solution = x;
         sol.row_index = ttsc_pkg::ROW_W'(i);
         sol.last_result = (i == 0);
         sol.overflow = cut;
         solution_queue.insert(solution_queue.size(), sol);
      end
      rows_taken = 0;
   endtask

   always @(posedge clock) begin
      ttsc_pkg::rsp_type want;
      logic              same;
      if (reset) begin
         fail_count = 0;
         solutions_seen = 0;
         cut_solutions = 0;
         rows_taken = 0;
         solution_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            solutions_seen++;
            if (rsp_data.overflow) cut_solutions++;
            if (solution_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("error: unexpected solution %h row %0d", rsp_data.solution,
                           rsp_data.row_index);
            end else begin
               want = solution_queue.pop_front();
               // any nan pattern stands for an expected nan
               same = (fp_nan(want.solution) ? fp_nan(rsp_data.solution)
                                             : want.solution === rsp_data.solution)
                      && want.row_index === rsp_data.row_index
                      && want.last_result === rsp_data.last_result
                      && want.overflow === rsp_data.overflow;
               if (!same) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("error: expected x=%h row=%0d last=%b ovf=%b",
                              want.solution, want.row_index, want.last_result,
                              want.overflow, ", got x=%h row=%0d last=%b ovf=%b",
                              rsp_data.solution, rsp_data.row_index,
                              rsp_data.last_result, rsp_data.overflow);
               end
            end
         end
         if (req_valid && req_ready) sweep_row(req_data);
      end
      solutions_due = solution_queue.size();
   end

endmodule

### test/tridiagonal_thomas_solver_core_tb.sv
// ----------------------------------------------------------------------------
// tridiagonal_thomas_solver_core_tb: stimulus and verdict for the solver
// feeds directed single and multi row systems, capacity-cut runs and random
// systems under random idling on both sides; the checker scores results
// ----------------------------------------------------------------------------
module tridiagonal_thomas_solver_core_tb;

   localparam int ROWS = ttsc_pkg::MAX_ROWS_DEF;
   localparam int ROW_TARGET = 360;
   localparam int STALL_LIMIT = 20000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   ttsc_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   ttsc_pkg::rsp_type rsp_data;

   int fail_count;
   int solutions_due;
   int solutions_seen;
   int cut_solutions;
   int rows_sent = 0;
   int systems_sent = 0;
   int idle_cycles = 0;

   // clock, 20 time units per period
   always #10 clock = ~clock;

   tridiagonal_thomas_solver_core #(.MAX_ROWS(ROWS)) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   ttsc_solution_checker #(.ROWS(ROWS)) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .solutions_due  (solutions_due),
      .solutions_seen (solutions_seen),
      .cut_solutions  (cut_solutions)
   );

   // idle draw 0..10, with every fourth block of 16 transactions back to back
   function automatic int idle_draw(input int n);
      if ((n % 64) < 16) return 0;
      return $urandom_range(0, 10);
   endfunction

   // mostly moderate floats, some raw patterns and specials
   function automatic logic [31:0] pick_float(input int lo_exp, input int hi_exp);
      logic [31:0] specials [8];
      int          pick;
      specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                   32'h7FC0_0000, 32'h0000_0001, 32'h7F7F_FFFF, 32'h807F_FFFF};
      pick = $urandom_range(0, 99);
      if (pick < 8) return $urandom();
      if (pick < 11) return specials[$urandom_range(0, 7)];
      return {1'($urandom()), 8'($urandom_range(lo_exp, hi_exp)), 23'($urandom())};
   endfunction

   function automatic ttsc_pkg::req_type plain_row(input logic last);
      ttsc_pkg::req_type r;
      r.sub_diag = pick_float(120, 126);
      r.main_diag = pick_float(128, 129);
      r.super_diag = pick_float(120, 126);
      r.rhs_value = pick_float(118, 136);
      r.is_last = last;
      return r;
   endfunction

   function automatic ttsc_pkg::req_type make_row(input logic [31:0] a, input logic [31:0] b,
                                                  input logic [31:0] c, input logic [31:0] d,
                                                  input logic last);
      ttsc_pkg::req_type r;
      r.sub_diag = a;
      r.main_diag = b;
      r.super_diag = c;
      r.rhs_value = d;
      r.is_last = last;
      return r;
   endfunction

   // one row transaction; valid stays up across back-to-back rows
   task automatic send_row(input ttsc_pkg::req_type r);
      int gap;
      gap = idle_draw(rows_sent);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      rows_sent++;
      if (r.is_last) systems_sent++;
   endtask

   // single-row system
   task automatic send_single(input logic [31:0] b, input logic [31:0] d);
      send_row(make_row($urandom(), b, $urandom(), d, 1'b1));
   endtask

   // random-content system of n rows, closed by the last mark
   task automatic send_system(input int n);
      for (int i = 0; i < n; i++) send_row(plain_row(i == n - 1));
   endtask

   // result side: a random stall, possibly none, before each solution
   initial begin
      int gap;
      int taken;
      taken = 0;
      @(posedge clock iff !reset);
      forever begin
         gap = idle_draw(taken + 7);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      int wait_cycles;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single rows: plain, zero and negative zero pivot, nan, infinity,
      // subnormal pivot, largest finite, all ones and all zeros
      send_single(32'h3F80_0000, 32'h4000_0000);
      send_single(32'h0000_0000, 32'h3F80_0000);
      send_single(32'h8000_0000, 32'hC040_0000);
      send_single(32'h7FC0_0001, 32'h3F80_0000);
      send_single(32'h7F80_0000, 32'h40A0_0000);
      send_single(32'h0000_0001, 32'h3F80_0000);
      send_single(32'h7F7F_FFFF, 32'h7F7F_FFFF);
      send_row(make_row('1, '1, '1, '1, 1'b1));
      send_row(make_row('0, '0, '0, '0, 1'b1));
      // two-row system
      send_row(make_row(32'hFFFF_FFFF, 32'h4000_0000, 32'h3F80_0000, 32'h4040_0000, 1'b0));
      send_row(make_row(32'h3F80_0000, 32'h4000_0000, 32'hFFFF_FFFF, 32'h4040_0000, 1'b1));
      // zero pivot in the middle of a system
      send_row(make_row(32'h0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0));
      send_row(make_row(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h4000_0000, 1'b0));
      send_row(make_row(32'h3F80_0000, 32'h4000_0000, 32'h0, 32'h4040_0000, 1'b1));

      // full capacity with the last mark on the final row, then a cut run
      send_system(ROWS);
      for (int i = 0; i < ROWS; i++) send_row(plain_row(1'b0));

      // random systems, mostly short, a few long and an occasional cut
      while (rows_sent < ROW_TARGET) begin
         int pick;
         pick = $urandom_range(0, 99);
         if (pick < 85) send_system($urandom_range(1, 8));
         else if (pick < 97) send_system($urandom_range(9, 30));
         else for (int i = 0; i < ROWS; i++) send_row(plain_row(1'b0));
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (solutions_due != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (300) @(posedge clock);

      $display("sent %0d rows in %0d systems, %0d solutions returned",
               rows_sent, systems_sent, solutions_seen);
      $display("%0d solutions came from capacity-cut runs, %0d mismatches",
               cut_solutions, fail_count);
      if (fail_count == 0 && solutions_due == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
